// ----- src/ufp_pkg.sv -----
// ----------------------------------------------------------------------------
// ufp_pkg
// Shared types and codes for the unit-capacity max-flow path block: command
// selectors, result status codes, controller states and datapath operations.
// ----------------------------------------------------------------------------
package ufp_pkg;

  // Fixed field widths of the stream words.
  localparam int FUNC_W = 2;
  localparam int NODE_W = 10;
  localparam int VAL_W  = 11;
  localparam int STAT_W = 3;

  // Command selector carried with each input word.
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD     = 2'd0,
    FN_COMPUTE = 2'd1,
    FN_FETCH   = 2'd2,
    FN_CLEAR   = 2'd3
  } func_e;

  // Status code carried with each output word.
  typedef enum logic [STAT_W-1:0] {
    ST_STORED  = 3'd0,
    ST_REJECT  = 3'd1,
    ST_FLOW    = 3'd2,
    ST_PLEN    = 3'd3,
    ST_VERTEX  = 3'd4,
    ST_NOMORE  = 3'd5,
    ST_CLEARED = 3'd6
  } status_e;

  // Life cycle of the loaded graph.
  typedef enum logic [1:0] {
    PH_LOAD,
    PH_READY,
    PH_EMIT,
    PH_DONE
  } phase_e;

  // Controller states.
  typedef enum logic [4:0] {
    S_RST_SWEEP,
    S_IDLE,
    S_ADD_RA,
    S_ADD_WA,
    S_ADD_RB,
    S_ADD_WB,
    S_CLR_START,
    S_CLR_SWEEP,
    S_CMP_START,
    S_FETCH_START,
    S_VIS_SWEEP,
    S_SINIT,
    S_POP,
    S_X,
    S_FE,
    S_E1,
    S_E2,
    S_AUG_START,
    S_AUG_W0,
    S_AUG_W1,
    S_PATH_START,
    S_P_W,
    S_P_Y,
    S_P_SINK,
    S_EMIT_RD,
    S_RESP
  } ctrl_state_e;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_SWEEP_FE,
    OP_SWEEP_VIS,
    OP_FLOW_START,
    OP_FETCH_START,
    OP_SINIT,
    OP_POP,
    OP_X,
    OP_FE,
    OP_E1,
    OP_E2,
    OP_AUG_START,
    OP_AUG_W0,
    OP_AUG_W1,
    OP_PATH_START,
    OP_P_W,
    OP_P_NEXT,
    OP_P_SINK,
    OP_EMIT_RD,
    OP_ADD_RA,
    OP_ADD_WA,
    OP_ADD_RB,
    OP_ADD_WB,
    OP_OUT
  } dp_op_e;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_e  op;
    status_e res;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic sweep_last;
    logic q_empty;
    logic x_goal;
    logic fe_zero;
    logic nxt_zero;
    logic y_one;
    logic y_sink;
    logic add_ok;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/ufp_dpath.sv -----
// ----------------------------------------------------------------------------
// ufp_dpath
// Datapath: edge store, node tables, search queue, path buffer, counters and
// the output word register. Performs one micro-operation per cycle.
// ----------------------------------------------------------------------------
module ufp_dpath
  import ufp_pkg::*;
#(
  parameter int MAX_NODES = 512,
  parameter int MAX_EDGES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_data_i,
  input  logic [NODE_W-1:0] from_node_i,
  input  logic [NODE_W-1:0] to_node_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output status_e           out_status_o,
  output logic [VAL_W-1:0]  out_value_o,
  output logic              out_last_o
);

  localparam int SLOTS = 2 * MAX_EDGES + 2;
  localparam int NODES1 = MAX_NODES + 1;
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int QW = $clog2(MAX_NODES);
  localparam int EW = $clog2(SLOTS);
  localparam int FLW = $clog2(MAX_EDGES + 1);
  localparam int AW = (NW > NODE_W) ? NW : NODE_W;

  // Memories.
  logic [NW-1:0] tgt_mem [SLOTS];
  logic          res_mem [SLOTS];
  logic [EW-1:0] nxt_mem [SLOTS];
  logic [EW-1:0] fe_mem  [NODES1];
  logic          vis_mem [NODES1];
  logic [EW-1:0] arr_mem [NODES1];
  logic [NW-1:0] q_mem   [MAX_NODES];
  logic [NW-1:0] pb_mem  [MAX_NODES];

  // Registered read data.
  logic [NW-1:0] tgt_rd_q;
  logic          res_rd_q;
  logic [EW-1:0] nxt_rd_q;
  logic [EW-1:0] fe_rd_q;
  logic          vis_rd_q;
  logic [EW-1:0] arr_rd_q;
  logic [NW-1:0] q_rd_q;
  logic [NW-1:0] pb_rd_q;

  // Memory port controls.
  logic          edge_we, edge_re, res_we, fe_we, fe_re, vis_we, vis_re;
  logic          arr_we, arr_re, q_we, q_re, pb_we, pb_re;
  logic [EW-1:0] edge_wa, edge_ra, res_wa;
  logic [NW-1:0] tgt_wd, fe_wa, fe_ra, vis_wa, vis_ra, arr_wa, arr_ra, q_wd, pb_wd;
  logic          res_wd, vis_wd;
  logic [EW-1:0] nxt_wd, fe_wd, arr_wd;
  logic [QW-1:0] q_wa, q_ra, pb_wa, pb_ra;

  // Registers.
  logic [NODE_W-1:0] nc_q, nc_d, a_q, a_d, b_q, b_d;
  logic [EW-1:0]     ec_q, ec_d, e_q, e_d;
  logic [FLW-1:0]    flow_q, flow_d;
  logic [NW-1:0]     sink_q, sink_d, y_q, y_d, len_q, len_d, cnt_q, cnt_d;
  logic [NW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [QW-1:0]     ptr_q, ptr_d;
  logic              mode_q, mode_d;
  logic              ov_q, ov_d, olast_q, olast_d;
  status_e           ost_q, ost_d;
  logic [VAL_W-1:0]  oval_q, oval_d;

  // Derived values.
  logic [AW-1:0] nc_x, eff_x, a_x, b_x;
  logic [NW-1:0] eff, a_node, b_node, start_node, goal_node;
  logic          ins, emit_last;

  // Effective node count, clamped to the supported range.
  assign nc_x  = AW'(nc_q);
  assign eff_x = (nc_x < AW'(2)) ? AW'(2) :
                 (nc_x > AW'(MAX_NODES)) ? AW'(MAX_NODES) : nc_x;
  assign eff   = NW'(eff_x);
  assign a_x   = AW'(a_q);
  assign b_x   = AW'(b_q);
  assign a_node = NW'(a_q);
  assign b_node = NW'(b_q);

  // Flow searches run source to sink; path searches run sink to source.
  assign start_node = mode_q ? sink_q : NW'(1);
  assign goal_node  = mode_q ? NW'(1) : sink_q;

  // An edge slot is taken when it has capacity, leads to an unvisited node,
  // and, on path searches, is a reverse slot.
  assign ins = (!mode_q || e_q[0]) && res_rd_q && !vis_rd_q;
  assign emit_last = ((NW + 1)'(ptr_q) + (NW + 1)'(1)) >= (NW + 1)'(len_q);

  // Status toward the controller.
  always_comb begin
    stat_o.sweep_last = (cnt_q == NW'(MAX_NODES));
    stat_o.q_empty    = (head_q == tail_q);
    stat_o.x_goal     = (q_rd_q == goal_node);
    stat_o.fe_zero    = (fe_rd_q == '0);
    stat_o.nxt_zero   = (nxt_rd_q == '0);
    stat_o.y_one      = (tgt_rd_q == NW'(1));
    stat_o.y_sink     = (tgt_rd_q == sink_q);
    stat_o.add_ok     = (a_x != '0) && (a_x <= eff_x) && (b_x != '0) &&
                        (b_x <= eff_x) && (ec_q < EW'(2 * MAX_EDGES));
    stat_o.emit_last  = emit_last;
    stat_o.out_free   = !ov_q || out_ready_i;
  end

  // Micro-operation decode.
  always_comb begin
    nc_d = nc_q; a_d = a_q; b_d = b_q; ec_d = ec_q; e_d = e_q; flow_d = flow_q;
    sink_d = sink_q; y_d = y_q; len_d = len_q; cnt_d = cnt_q; head_d = head_q;
    tail_d = tail_q; ptr_d = ptr_q; mode_d = mode_q; ov_d = ov_q;
    olast_d = olast_q; ost_d = ost_q; oval_d = oval_q;
    edge_we = 1'b0; edge_re = 1'b0; res_we = 1'b0; fe_we = 1'b0; fe_re = 1'b0;
    vis_we = 1'b0; vis_re = 1'b0; arr_we = 1'b0; arr_re = 1'b0;
    q_we = 1'b0; q_re = 1'b0; pb_we = 1'b0; pb_re = 1'b0;
    edge_wa = '0; edge_ra = '0; res_wa = '0; tgt_wd = '0; fe_wa = '0; fe_ra = '0;
    vis_wa = '0; vis_ra = '0; arr_wa = '0; arr_ra = '0; q_wd = '0; pb_wd = '0;
    res_wd = 1'b0; vis_wd = 1'b0; nxt_wd = '0; fe_wd = '0; arr_wd = '0;
    q_wa = '0; q_ra = '0; pb_wa = '0; pb_ra = '0;

    if (cfg_we_i) begin
      nc_d = cfg_data_i;
    end
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_CAPTURE: begin
        a_d = from_node_i;
        b_d = to_node_i;
      end
      OP_CLEAR: begin
        ec_d   = EW'(1);
        flow_d = '0;
        sink_d = NW'(2);
        ptr_d  = '0;
        len_d  = '0;
      end
      OP_SWEEP_FE: begin
        fe_we = 1'b1;
        fe_wa = cnt_q;
        cnt_d = stat_o.sweep_last ? '0 : cnt_q + NW'(1);
      end
      OP_SWEEP_VIS: begin
        vis_we = 1'b1;
        vis_wa = cnt_q;
        cnt_d  = stat_o.sweep_last ? '0 : cnt_q + NW'(1);
      end
      OP_FLOW_START: begin
        sink_d = eff;
        flow_d = '0;
        mode_d = 1'b0;
      end
      OP_FETCH_START: begin
        mode_d = 1'b1;
      end
      OP_SINIT: begin
        q_we   = 1'b1;
        q_wd   = start_node;
        vis_we = 1'b1;
        vis_wa = start_node;
        vis_wd = 1'b1;
        head_d = '0;
        tail_d = NW'(1);
      end
      OP_POP: begin
        q_re   = 1'b1;
        q_ra   = head_q[QW-1:0];
        head_d = head_q + NW'(1);
      end
      OP_X: begin
        fe_re = 1'b1;
        fe_ra = q_rd_q;
      end
      OP_FE: begin
        e_d     = fe_rd_q;
        edge_re = 1'b1;
        edge_ra = fe_rd_q;
      end
      OP_E1: begin
        vis_re = 1'b1;
        vis_ra = tgt_rd_q;
      end
      OP_E2: begin
        if (ins) begin
          vis_we = 1'b1;
          vis_wa = tgt_rd_q;
          vis_wd = 1'b1;
          arr_we = 1'b1;
          arr_wa = tgt_rd_q;
          arr_wd = e_q;
          q_we   = 1'b1;
          q_wa   = tail_q[QW-1:0];
          q_wd   = tgt_rd_q;
          tail_d = tail_q + NW'(1);
        end
        e_d     = nxt_rd_q;
        edge_re = 1'b1;
        edge_ra = nxt_rd_q;
      end
      OP_AUG_START: begin
        flow_d = flow_q + FLW'(1);
        arr_re = 1'b1;
        arr_ra = sink_q;
      end
      OP_AUG_W0: begin
        e_d     = arr_rd_q;
        res_we  = 1'b1;
        res_wa  = arr_rd_q;
        edge_re = 1'b1;
        edge_ra = {arr_rd_q[EW-1:1], ~arr_rd_q[0]};
      end
      OP_AUG_W1: begin
        res_we = 1'b1;
        res_wa = {e_q[EW-1:1], ~e_q[0]};
        res_wd = 1'b1;
        arr_re = 1'b1;
        arr_ra = tgt_rd_q;
      end
      OP_PATH_START: begin
        y_d    = NW'(1);
        len_d  = '0;
        arr_re = 1'b1;
        arr_ra = NW'(1);
      end
      OP_P_W: begin
        pb_we   = 1'b1;
        pb_wa   = len_q[QW-1:0];
        pb_wd   = y_q;
        len_d   = len_q + NW'(1);
        res_we  = 1'b1;
        res_wa  = arr_rd_q;
        edge_re = 1'b1;
        edge_ra = {arr_rd_q[EW-1:1], ~arr_rd_q[0]};
      end
      OP_P_NEXT: begin
        y_d    = tgt_rd_q;
        arr_re = 1'b1;
        arr_ra = tgt_rd_q;
      end
      OP_P_SINK: begin
        pb_we = 1'b1;
        pb_wa = len_q[QW-1:0];
        pb_wd = sink_q;
        len_d = len_q + NW'(1);
      end
      OP_EMIT_RD: begin
        pb_re = 1'b1;
        pb_ra = ptr_q;
      end
      OP_ADD_RA: begin
        fe_re = 1'b1;
        fe_ra = a_node;
      end
      OP_ADD_WA: begin
        edge_we = 1'b1;
        edge_wa = ec_q + EW'(1);
        tgt_wd  = b_node;
        nxt_wd  = fe_rd_q;
        res_we  = 1'b1;
        res_wa  = ec_q + EW'(1);
        res_wd  = 1'b1;
        fe_we   = 1'b1;
        fe_wa   = a_node;
        fe_wd   = ec_q + EW'(1);
      end
      OP_ADD_RB: begin
        fe_re = 1'b1;
        fe_ra = b_node;
      end
      OP_ADD_WB: begin
        edge_we = 1'b1;
        edge_wa = ec_q + EW'(2);
        tgt_wd  = a_node;
        nxt_wd  = fe_rd_q;
        res_we  = 1'b1;
        res_wa  = ec_q + EW'(2);
        fe_we   = 1'b1;
        fe_wa   = b_node;
        fe_wd   = ec_q + EW'(2);
        ec_d    = ec_q + EW'(2);
      end
      OP_OUT: begin
        ov_d    = 1'b1;
        ost_d   = cmd_i.res;
        olast_d = 1'b0;
        unique case (cmd_i.res)
          ST_FLOW:   oval_d = VAL_W'(flow_q);
          ST_PLEN:   oval_d = VAL_W'(len_q);
          ST_VERTEX: begin
            oval_d  = VAL_W'(pb_rd_q);
            olast_d = emit_last;
            ptr_d   = emit_last ? '0 : ptr_q + QW'(1);
          end
          default:   oval_d = '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q   <= NODE_W'(2);
      ec_q   <= EW'(1);
      flow_q <= '0;
      sink_q <= NW'(2);
      len_q  <= '0;
      cnt_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
      ptr_q  <= '0;
      mode_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      nc_q   <= nc_d;
      ec_q   <= ec_d;
      flow_q <= flow_d;
      sink_q <= sink_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
      head_q <= head_d;
      tail_q <= tail_d;
      ptr_q  <= ptr_d;
      mode_q <= mode_d;
      ov_q   <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    e_q     <= e_d;
    y_q     <= y_d;
    ost_q   <= ost_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  // Edge store: target, capacity and list link per slot.
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      tgt_mem[edge_wa] <= tgt_wd;
    end
    if (edge_re) begin
      tgt_rd_q <= tgt_mem[edge_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[res_wa] <= res_wd;
    end
    if (edge_re) begin
      res_rd_q <= res_mem[edge_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      nxt_mem[edge_wa] <= nxt_wd;
    end
    if (edge_re) begin
      nxt_rd_q <= nxt_mem[edge_ra];
    end
  end

  // List heads per node.
  always_ff @(posedge clk_i) begin
    if (fe_we) begin
      fe_mem[fe_wa] <= fe_wd;
    end
    if (fe_re) begin
      fe_rd_q <= fe_mem[fe_ra];
    end
  end

  // Visited marks per node.
  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (vis_re) begin
      vis_rd_q <= vis_mem[vis_ra];
    end
  end

  // Arrival slot per node.
  always_ff @(posedge clk_i) begin
    if (arr_we) begin
      arr_mem[arr_wa] <= arr_wd;
    end
    if (arr_re) begin
      arr_rd_q <= arr_mem[arr_ra];
    end
  end

  // Search queue.
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (q_re) begin
      q_rd_q <= q_mem[q_ra];
    end
  end

  // Path buffer.
  always_ff @(posedge clk_i) begin
    if (pb_we) begin
      pb_mem[pb_wa] <= pb_wd;
    end
    if (pb_re) begin
      pb_rd_q <= pb_mem[pb_ra];
    end
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = ost_q;
  assign out_value_o  = oval_q;
  assign out_last_o   = olast_q;

`ifndef SYNTH
  // The queue read pointer never passes the write pointer.
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("search queue head passed tail");

  // Slots are allocated in pairs, so the last used slot is always odd.
  a_slot_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ec_q[0]) else $error("edge slot count lost pairing");
`endif

endmodule

// ----- src/ufp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ufp_ctrl
// Controller: sequences edge loads, clearing sweeps, breadth-first searches,
// augmentation, path extraction and result delivery.
// ----------------------------------------------------------------------------
module ufp_ctrl
  import ufp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  func_e    func_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  status_e     res_q, res_d;
  logic        mode_q, mode_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    res_d   = res_q;
    mode_d  = mode_q;
    unique case (state_q)
      S_RST_SWEEP: if (stat_i.sweep_last) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FN_ADD: state_d = S_ADD_RA;
            FN_COMPUTE: begin
              if (phase_q == PH_LOAD) begin
                state_d = S_CMP_START;
              end else begin
                res_d   = ST_FLOW;
                state_d = S_RESP;
              end
            end
            FN_FETCH: begin
              priority if (phase_q == PH_READY) begin
                state_d = S_FETCH_START;
              end else if (phase_q == PH_EMIT) begin
                state_d = S_EMIT_RD;
              end else begin
                res_d   = ST_NOMORE;
                state_d = S_RESP;
              end
            end
            FN_CLEAR: state_d = S_CLR_START;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_RA: begin
        if (phase_q != PH_LOAD || !stat_i.add_ok) begin
          res_d   = ST_REJECT;
          state_d = S_RESP;
        end else begin
          state_d = S_ADD_WA;
        end
      end
      S_ADD_WA: state_d = S_ADD_RB;
      S_ADD_RB: state_d = S_ADD_WB;
      S_ADD_WB: begin
        res_d   = ST_STORED;
        state_d = S_RESP;
      end
      S_CLR_START: begin
        phase_d = PH_LOAD;
        state_d = S_CLR_SWEEP;
      end
      S_CLR_SWEEP: begin
        if (stat_i.sweep_last) begin
          res_d   = ST_CLEARED;
          state_d = S_RESP;
        end
      end
      S_CMP_START: begin
        mode_d  = 1'b0;
        state_d = S_VIS_SWEEP;
      end
      S_FETCH_START: begin
        mode_d  = 1'b1;
        state_d = S_VIS_SWEEP;
      end
      S_VIS_SWEEP: if (stat_i.sweep_last) state_d = S_SINIT;
      S_SINIT: state_d = S_POP;
      S_POP: begin
        if (stat_i.q_empty) begin
          if (mode_q) begin
            phase_d = PH_DONE;
            res_d   = ST_NOMORE;
          end else begin
            phase_d = PH_READY;
            res_d   = ST_FLOW;
          end
          state_d = S_RESP;
        end else begin
          state_d = S_X;
        end
      end
      S_X: begin
        if (stat_i.x_goal) begin
          state_d = mode_q ? S_PATH_START : S_AUG_START;
        end else begin
          state_d = S_FE;
        end
      end
      S_FE: state_d = stat_i.fe_zero ? S_POP : S_E1;
      S_E1: state_d = S_E2;
      S_E2: state_d = stat_i.nxt_zero ? S_POP : S_E1;
      S_AUG_START: state_d = S_AUG_W0;
      S_AUG_W0: state_d = S_AUG_W1;
      S_AUG_W1: state_d = stat_i.y_one ? S_VIS_SWEEP : S_AUG_W0;
      S_PATH_START: state_d = S_P_W;
      S_P_W: state_d = S_P_Y;
      S_P_Y: state_d = stat_i.y_sink ? S_P_SINK : S_P_W;
      S_P_SINK: begin
        phase_d = PH_EMIT;
        res_d   = ST_PLEN;
        state_d = S_RESP;
      end
      S_EMIT_RD: begin
        res_d   = ST_VERTEX;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          if (res_q == ST_VERTEX && stat_i.emit_last) begin
            phase_d = PH_READY;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: one datapath operation per state.
  always_comb begin
    cmd_o.res  = res_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_RST_SWEEP, S_CLR_SWEEP: cmd_o.op = OP_SWEEP_FE;
      S_IDLE:        cmd_o.op = in_valid_i ? OP_CAPTURE : OP_NONE;
      S_ADD_RA:      cmd_o.op = (phase_q == PH_LOAD && stat_i.add_ok) ? OP_ADD_RA : OP_NONE;
      S_ADD_WA:      cmd_o.op = OP_ADD_WA;
      S_ADD_RB:      cmd_o.op = OP_ADD_RB;
      S_ADD_WB:      cmd_o.op = OP_ADD_WB;
      S_CLR_START:   cmd_o.op = OP_CLEAR;
      S_CMP_START:   cmd_o.op = OP_FLOW_START;
      S_FETCH_START: cmd_o.op = OP_FETCH_START;
      S_VIS_SWEEP:   cmd_o.op = OP_SWEEP_VIS;
      S_SINIT:       cmd_o.op = OP_SINIT;
      S_POP:         cmd_o.op = stat_i.q_empty ? OP_NONE : OP_POP;
      S_X:           cmd_o.op = stat_i.x_goal ? OP_NONE : OP_X;
      S_FE:          cmd_o.op = OP_FE;
      S_E1:          cmd_o.op = OP_E1;
      S_E2:          cmd_o.op = OP_E2;
      S_AUG_START:   cmd_o.op = OP_AUG_START;
      S_AUG_W0:      cmd_o.op = OP_AUG_W0;
      S_AUG_W1:      cmd_o.op = OP_AUG_W1;
      S_PATH_START:  cmd_o.op = OP_PATH_START;
      S_P_W:         cmd_o.op = OP_P_W;
      S_P_Y:         cmd_o.op = stat_i.y_sink ? OP_NONE : OP_P_NEXT;
      S_P_SINK:      cmd_o.op = OP_P_SINK;
      S_EMIT_RD:     cmd_o.op = OP_EMIT_RD;
      S_RESP:        cmd_o.op = stat_i.out_free ? OP_OUT : OP_NONE;
      default:       cmd_o.op = OP_NONE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST_SWEEP;
      phase_q <= PH_LOAD;
      res_q   <= ST_STORED;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      res_q   <= res_d;
      mode_q  <= mode_d;
    end
  end

`ifndef SYNTH
  // Path words are only offered after a path has been built.
  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q == PH_EMIT) |-> $past(state_q == S_P_SINK))
    else $error("emit phase entered without a built path");

  // A pending result holds the controller until the output slot frees.
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !stat_i.out_free) |=> (state_q == S_RESP))
    else $error("result dropped while output busy");

  // Edges are only written while the graph is loading.
  a_add_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD_WA || state_q == S_ADD_WB) |-> (phase_q == PH_LOAD))
    else $error("edge written after compute");
`endif

endmodule

// ----- src/unit_capacity_max_flow_paths.sv -----
// ----------------------------------------------------------------------------
// unit_capacity_max_flow_paths
// Unit-capacity maximum flow over a loaded directed graph, with listing of
// the edge-disjoint source-to-sink paths one word at a time.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: func; tdata: from_node, to_node
//  m_axis    out        tuser: status; tdata: value; tlast: last_of_path
//  cfg       in         node_count write, no read-back
//
//  Compute runs searches until none reaches the sink; each search begins
//  with a visited-mark sweep over the node table, then pops nodes and scans
//  their edges, and each augmenting path is walked back hop by hop.
//  After reset and on clear, a pass over the node table empties the list
//  heads while input is held off. One command is in flight at a time; the
//  output register lets a new word be taken while a result waits.
// ----------------------------------------------------------------------------
module unit_capacity_max_flow_paths
  import ufp_pkg::*;
#(
  parameter int MAX_NODES = 512,
  parameter int MAX_EDGES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] from_node, [19:10] to_node
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] value
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  status_e          out_status;
  logic [VAL_W-1:0] out_value;

  // Sequencer.
  ufp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .func_i     (func_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  ufp_dpath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .from_node_i  (s_axis_tdata[9:0]),
    .to_node_i    (s_axis_tdata[19:10]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {5'd0, out_value};

endmodule
